// ===== sv/smf_pkg.sv =====
// shared types for the sliding window median filter
// sequencer states, sorter commands and config register constants; no dependencies
package smf_pkg;

  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] WL_RESET = 6'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_INS_BEGIN,
    ST_RB_RD,
    ST_RB_GO,
    ST_RB_WAIT,
    ST_RD_OLD,
    ST_DEL,
    ST_DEL_WAIT,
    ST_INS_WAIT,
    ST_MED,
    ST_EMIT,
    ST_NEXT
  } smf_state_t;

  typedef enum logic [1:0] {
    SORT_FILL,
    SORT_INSERT,
    SORT_DELETE,
    SORT_READ
  } smf_sort_op_t;

  typedef enum logic [2:0] {
    SS_IDLE,
    SS_FILL,
    SS_INS_CMP,
    SS_INS_PUT,
    SS_DEL_CMP,
    SS_RD_WAIT
  } smf_sort_state_t;

  typedef struct packed {
    logic         start;
    smf_sort_op_t op;
  } smf_sort_cmd_t;

endpackage

// ===== sv/smf_sorter.sv =====
// sorted window store with one shared compare unit stepping over it
// fill, insert, delete and read of a descending list; depends on smf_pkg
module smf_sorter #(
  parameter int MAX_WINDOW   = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smf_pkg::smf_sort_cmd_t              cmd,
  input  logic [SAMPLE_WIDTH-1:0]             value,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     count,
  output logic                                busy,
  output logic [SAMPLE_WIDTH-1:0]             data
);
  import smf_pkg::*;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW+1);

  logic [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] rd_r;

  smf_sort_state_t         state_r, state_nxt;
  logic [SAMPLE_WIDTH-1:0] val_r, val_nxt;
  logic [LEN_W-1:0]        cnt_r, cnt_nxt;
  logic [LEN_W-1:0]        j_r, j_nxt;
  logic                    found_r, found_nxt;
  logic [SAMPLE_WIDTH-1:0] data_r, data_nxt;

  logic                    we;
  logic [IDX_W-1:0]        wa;
  logic [SAMPLE_WIDTH-1:0] wd;
  logic [IDX_W-1:0]        ra;
  logic [LEN_W-1:0]        j_dec, j_dec2, j_inc, cnt_dec;

  assign j_dec   = j_r - LEN_W'(1);
  assign j_dec2  = j_r - LEN_W'(2);
  assign j_inc   = j_r + LEN_W'(1);
  assign cnt_dec = cnt_r - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    cnt_r   <= cnt_nxt;
    j_r     <= j_nxt;
    found_r <= found_nxt;
    data_r  <= data_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    found_nxt = found_r;
    data_nxt  = data_r;
    we        = 1'b0;
    wa        = j_r[IDX_W-1:0];
    wd        = val_r;
    ra        = j_r[IDX_W-1:0];
    case (state_r)
      SS_IDLE: begin
        if (cmd.start) begin
          val_nxt = value;
          cnt_nxt = count;
          case (cmd.op)
            SORT_FILL: begin
              j_nxt     = '0;
              state_nxt = SS_FILL;
            end
            SORT_INSERT: begin
              j_nxt = count;
              if (count == '0) begin
                state_nxt = SS_INS_PUT;
              end else begin
                ra        = IDX_W'(count - LEN_W'(1));
                state_nxt = SS_INS_CMP;
              end
            end
            SORT_DELETE: begin
              j_nxt     = '0;
              found_nxt = 1'b0;
              ra        = '0;
              state_nxt = SS_DEL_CMP;
            end
            SORT_READ: begin
              ra        = IDX_W'(count);
              state_nxt = SS_RD_WAIT;
            end
            default: begin
              state_nxt = SS_IDLE;
            end
          endcase
        end
      end
      SS_FILL: begin
        we    = 1'b1;
        j_nxt = j_inc;
        if (j_r == cnt_dec) begin
          state_nxt = SS_IDLE;
        end
      end
      SS_INS_CMP: begin
        // rd_r holds the entry just above the hole at j
        we = 1'b1;
        if ($signed(rd_r) < $signed(val_r)) begin
          wd    = rd_r;
          j_nxt = j_dec;
          if (j_r == LEN_W'(1)) begin
            state_nxt = SS_INS_PUT;
          end else begin
            ra = j_dec2[IDX_W-1:0];
          end
        end else begin
          state_nxt = SS_IDLE;
        end
      end
      SS_INS_PUT: begin
        we        = 1'b1;
        state_nxt = SS_IDLE;
      end
      SS_DEL_CMP: begin
        // once the victim is found every later entry moves up one slot
        if (found_r) begin
          we = 1'b1;
          wa = j_dec[IDX_W-1:0];
          wd = rd_r;
        end else if (rd_r == val_r) begin
          found_nxt = 1'b1;
        end
        if (j_r == cnt_dec) begin
          state_nxt = SS_IDLE;
        end else begin
          j_nxt = j_inc;
          ra    = j_inc[IDX_W-1:0];
        end
      end
      SS_RD_WAIT: begin
        data_nxt  = rd_r;
        state_nxt = SS_IDLE;
      end
      default: begin
        state_nxt = SS_IDLE;
      end
    endcase
  end

  assign busy = (state_r != SS_IDLE);
  assign data = data_r;

endmodule

// ===== sv/sliding_window_median_filter.sv =====
// Running median filter over a sliding window of window_length samples.
// Samples enter on in_* (tdata: sample, tlast: last sample of a stream) and
// medians leave on out_* (tdata: median, tlast: last median this word causes).
// cfg_* writes the window length (2..MAX_WINDOW, clamped); write it only while
// the block is idle. The first word of a stream fills the window with copies
// of itself; the fill gives no output. Every later word is one insert, made
// by the delete and insert passes of the sorter, which steps its one comparator
// over the sorted store one entry per cycle. A word with tlast adds length/2
// more inserts. An insert gives a result once length/2 inserts have been made
// in the stream. The first insert after a length change rebuilds the sorted
// store from the ring. in_tready is high only while the block waits for a
// word. A stalled receiver holds the output register, and the block waits
// before its next result until that word is taken.
// Reset returns the length to 5 and marks the next word as a stream start.
module sliding_window_median_filter #(
  parameter int MAX_WINDOW   = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      in_tdata,   // sample
  input  logic                                   in_tlast,   // is_last
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      out_tdata,  // median_value
  output logic                                   out_tlast,  // end_of_run
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [smf_pkg::CFG_W-1:0]              cfg_data    // window_length
);
  import smf_pkg::*;

  localparam int DW    = ((SAMPLE_WIDTH+7)/8)*8;
  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW+1);
  localparam int CMPW  = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  logic [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] ring_rd_r;
  logic                    ring_we;
  logic [IDX_W-1:0]        ring_wa, ring_ra;
  logic [SAMPLE_WIDTH-1:0] ring_wd;

  smf_state_t              state_r, state_nxt;
  logic [CFG_W-1:0]        wl_r, wl_nxt;
  logic                    active_r, active_nxt;
  logic                    dirty_r, dirty_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [LEN_W-1:0]        cnt_r, cnt_nxt;
  logic [LEN_W-1:0]        left_r, left_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;

  logic [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic                    last_r, last_nxt;
  logic [LEN_W-1:0]        idx_r, idx_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  smf_sort_cmd_t           sort_cmd;
  logic [SAMPLE_WIDTH-1:0] sort_value;
  logic [LEN_W-1:0]        sort_count;
  logic                    sort_busy;
  logic [SAMPLE_WIDTH-1:0] sort_data;

  logic [CMPW-1:0]         wl_ext;
  logic [LEN_W-1:0]        len, half, len_dec, cnt_inc, pos_inc;
  logic                    in_acc, cfg_acc;

  smf_sorter #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_sorter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (sort_cmd),
    .value (sort_value),
    .count (sort_count),
    .busy  (sort_busy),
    .data  (sort_data)
  );

  // clamp the configured length to 2..MAX_WINDOW
  assign wl_ext = CMPW'(wl_r);
  always_comb begin
    if (wl_ext < CMPW'(2)) begin
      len = LEN_W'(2);
    end else if (wl_ext > CMPW'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(wl_ext);
    end
  end

  assign half    = len >> 1;
  assign len_dec = len - LEN_W'(1);
  assign cnt_inc = (cnt_r < LEN_W'(MAX_WINDOW)) ? cnt_r + LEN_W'(1) : cnt_r;
  assign pos_inc = LEN_W'(pos_r) + LEN_W'(1);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_wa] <= ring_wd;
    end
    ring_rd_r <= ring[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wl_r         <= WL_RESET;
      active_r     <= 1'b0;
      dirty_r      <= 1'b0;
      pos_r        <= '0;
      cnt_r        <= '0;
      left_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wl_r         <= wl_nxt;
      active_r     <= active_nxt;
      dirty_r      <= dirty_nxt;
      pos_r        <= pos_nxt;
      cnt_r        <= cnt_nxt;
      left_r       <= left_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    wl_nxt         = wl_r;
    active_nxt     = active_r;
    dirty_nxt      = dirty_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    left_nxt       = left_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    sample_nxt     = sample_r;
    last_nxt       = last_r;
    idx_nxt        = idx_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    ring_we        = 1'b0;
    ring_wa        = pos_r;
    ring_wd        = sample_r;
    ring_ra        = pos_r;
    sort_cmd.start = 1'b0;
    sort_cmd.op    = SORT_INSERT;
    sort_value     = sample_r;
    sort_count     = len_dec;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sample_nxt = in_tdata[SAMPLE_WIDTH-1:0];
          last_nxt   = in_tlast;
          idx_nxt    = '0;
          if (active_r) begin
            left_nxt  = in_tlast ? half + LEN_W'(1) : LEN_W'(1);
            state_nxt = ST_INS_BEGIN;
          end else begin
            // stream start: sorter fills its store while the ring is swept here
            left_nxt       = in_tlast ? half : '0;
            sort_cmd.start = 1'b1;
            sort_cmd.op    = SORT_FILL;
            sort_value     = in_tdata[SAMPLE_WIDTH-1:0];
            sort_count     = LEN_W'(MAX_WINDOW);
            state_nxt      = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (idx_r < LEN_W'(MAX_WINDOW)) begin
          ring_we = 1'b1;
          ring_wa = idx_r[IDX_W-1:0];
          idx_nxt = idx_r + LEN_W'(1);
        end else if (!sort_busy) begin
          active_nxt = 1'b1;
          dirty_nxt  = 1'b0;
          pos_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = (left_r == '0) ? ST_IDLE : ST_INS_BEGIN;
        end
      end
      ST_INS_BEGIN: begin
        if (LEN_W'(pos_r) >= len) begin
          pos_nxt = '0;
        end
        idx_nxt   = '0;
        state_nxt = dirty_r ? ST_RB_RD : ST_RD_OLD;
      end
      ST_RB_RD: begin
        ring_ra   = idx_r[IDX_W-1:0];
        state_nxt = ST_RB_GO;
      end
      ST_RB_GO: begin
        sort_cmd.start = 1'b1;
        sort_cmd.op    = SORT_INSERT;
        sort_value     = ring_rd_r;
        sort_count     = idx_r;
        state_nxt      = ST_RB_WAIT;
      end
      ST_RB_WAIT: begin
        if (!sort_busy) begin
          if (idx_r == len_dec) begin
            dirty_nxt = 1'b0;
            state_nxt = ST_RD_OLD;
          end else begin
            idx_nxt   = idx_r + LEN_W'(1);
            state_nxt = ST_RB_RD;
          end
        end
      end
      ST_RD_OLD: begin
        state_nxt = ST_DEL;
      end
      ST_DEL: begin
        // ring_rd_r holds the oldest sample, now overwritten
        ring_we        = 1'b1;
        sort_cmd.start = 1'b1;
        sort_cmd.op    = SORT_DELETE;
        sort_value     = ring_rd_r;
        sort_count     = len;
        state_nxt      = ST_DEL_WAIT;
      end
      ST_DEL_WAIT: begin
        if (!sort_busy) begin
          sort_cmd.start = 1'b1;
          sort_cmd.op    = SORT_INSERT;
          state_nxt      = ST_INS_WAIT;
        end
      end
      ST_INS_WAIT: begin
        if (!sort_busy) begin
          pos_nxt = (pos_inc >= len) ? '0 : pos_inc[IDX_W-1:0];
          cnt_nxt = cnt_inc;
          if (cnt_inc >= half) begin
            sort_cmd.start = 1'b1;
            sort_cmd.op    = SORT_READ;
            sort_count     = half;
            state_nxt      = ST_MED;
          end else begin
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_MED: begin
        if (!sort_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = sort_data;
          out_last_nxt   = (left_r == LEN_W'(1));
          state_nxt      = ST_NEXT;
        end
      end
      ST_NEXT: begin
        left_nxt = left_r - LEN_W'(1);
        if (left_r == LEN_W'(1)) begin
          if (last_r) begin
            active_nxt = 1'b0;
            pos_nxt    = '0;
            cnt_nxt    = '0;
          end
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_INS_BEGIN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_acc) begin
      wl_nxt    = cfg_data;
      dirty_nxt = 1'b1;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DW'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule

// ===== sim/smf_median_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for sliding_window_median_filter: tracks the window from accepted
// sample and length words, predicts each median word and compares in order
// depends on smf_pkg for the length register width and its reset value
module smf_median_checker #(
  parameter int MAX_WINDOW   = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  in_tdata,   // sample
  input  logic                               in_tlast,   // is_last
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  out_tdata,  // median_value
  input  logic                               out_tlast,  // end_of_run
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [smf_pkg::CFG_W-1:0]          cfg_data,   // window_length
  output int                                 pending,
  output int                                 fail_count
);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct {
    sample_t median;
    logic    eor;
  } median_word_t;

  median_word_t              expected_medians[$];
  sample_t                   ring [MAX_WINDOW];
  int                        replace_slot;
  int                        inserts_done;
  bit                        in_stream;
  logic [smf_pkg::CFG_W-1:0] length_reg;
  int                        errs  = 0;
  int                        shown = 0;

  assign fail_count = errs;

  function automatic int active_length();
    int n;
    n = length_reg;
    if (n < 2) n = 2;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    return n;
  endfunction

  // rank len/2 of the first len ring slots, largest first
  function automatic sample_t window_median(int len);
    sample_t ranked [MAX_WINDOW];
    sample_t v;
    int      j;
    for (int i = 0; i < len; i++) begin
      v = ring[i];
      j = i;
      while (j > 0 && ranked[j-1] < v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    return ranked[len/2];
  endfunction

  task automatic insert_sample(input sample_t s, output bit due, output sample_t med);
    int len;
    len = active_length();
    if (replace_slot >= len) replace_slot = 0;
    ring[replace_slot] = s;
    replace_slot++;
    if (replace_slot >= len) replace_slot = 0;
    if (inserts_done < MAX_WINDOW) inserts_done++;
    due = (inserts_done >= len / 2);
    med = window_median(len);
  endtask

  task automatic predict_medians(input sample_t s, input logic last);
    sample_t meds[$];
    bit      due;
    sample_t med;
    int      pad;
    if (!in_stream) begin
      // stream start: whole ring takes the sample, no insert
      for (int i = 0; i < MAX_WINDOW; i++) ring[i] = s;
      replace_slot = 0;
      inserts_done = 0;
      in_stream    = 1'b1;
    end else begin
      insert_sample(s, due, med);
      if (due) meds.push_back(med);
    end
    if (last) begin
      pad = active_length() / 2;
      for (int i = 0; i < pad; i++) begin
        insert_sample(s, due, med);
        if (due) meds.push_back(med);
      end
      in_stream    = 1'b0;
      replace_slot = 0;
      inserts_done = 0;
    end
    foreach (meds[i])
      expected_medians.push_back('{median: meds[i], eor: (i == meds.size() - 1)});
  endtask

  task automatic report_mismatch(input string msg);
    errs++;
    if (shown < 40) begin
      $display("%0t mismatch: %s", $realtime, msg);
      shown++;
    end
  endtask

  always @(posedge clk) begin : watch
    median_word_t want;
    if (!rst_n) begin
      length_reg   = smf_pkg::WL_RESET;
      in_stream    = 1'b0;
      replace_slot = 0;
      inserts_done = 0;
      expected_medians.delete();
    end else begin
      if (cfg_valid && cfg_ready) length_reg = cfg_data;
      if (in_tvalid && in_tready)
        predict_medians(in_tdata[SAMPLE_WIDTH-1:0], in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("unexpected word, median %0d",
                                    $signed(out_tdata[SAMPLE_WIDTH-1:0])));
        end else begin
          want = expected_medians.pop_front();
          if (out_tdata[SAMPLE_WIDTH-1:0] !== want.median)
            report_mismatch($sformatf("median %0d, expected %0d",
                                      $signed(out_tdata[SAMPLE_WIDTH-1:0]), want.median));
          if (out_tlast !== want.eor)
            report_mismatch($sformatf("tlast %b, expected %b", out_tlast, want.eor));
        end
      end
    end
    pending <= expected_medians.size();
  end

endmodule

// ===== sim/sliding_window_median_filter_tb.sv =====
`timescale 1ns / 1ps
// top of the median filter testbench: clock, reset, sample streams and length writes
// depends on smf_pkg, sliding_window_median_filter and smf_median_checker
module sliding_window_median_filter_tb;

  import smf_pkg::*;

  localparam int MAX_WINDOW   = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int DW           = ((SAMPLE_WIDTH+7)/8)*8;
  localparam int CLK_PERIOD   = 8;
  localparam int SETTLE       = 1200;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RAND_ITEMS   = 300;
  localparam int QUIET_AFTER  = 240;

  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_EDGE
  } spread_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [DW-1:0]    in_tdata;   // sample
  logic             in_tlast;   // is_last
  logic             out_tvalid;
  logic             out_tready;
  logic [DW-1:0]    out_tdata;  // median_value
  logic             out_tlast;  // end_of_run
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;   // window_length

  int pending;
  int fail_count;
  int cycles = 0;
  int rand_sent = 0;
  bit quiet = 1'b0;

  sliding_window_median_filter #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  smf_median_checker #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD/2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 4) != 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] gen_sample(spread_t spread);
    logic [SAMPLE_WIDTH-1:0] edges [5];
    edges = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
    case (spread)
      SPREAD_NARROW: return SAMPLE_WIDTH'($urandom_range(0, 8)) - SAMPLE_WIDTH'(4);
      SPREAD_EDGE:   return edges[$urandom_range(0, 4)];
      default:       return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // mostly short windows, now and then the largest or an out of range value
  function automatic logic [CFG_W-1:0] pick_length();
    case ($urandom_range(0, 19))
      0:       return CFG_W'(MAX_WINDOW);
      1:       return CFG_W'($urandom_range(MAX_WINDOW + 1, 63));
      2:       return CFG_W'($urandom_range(0, 1));
      3:       return CFG_W'(2);
      default: return CFG_W'($urandom_range(2, 9));
    endcase
  endfunction

  task automatic send_word(input logic [SAMPLE_WIDTH-1:0] s, input logic last);
    int gap;
    in_tdata  <= DW'(s);
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every expected median, then long enough for a silent insert to finish
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] len);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic play_stream(input int n, input spread_t spread, input int change_at);
    for (int k = 0; k < n; k++) begin
      if (k == change_at) begin
        settle_idle();
        write_length(CFG_W'($urandom_range(1, 6)));
      end
      send_word(gen_sample(spread), k == n - 1);
      rand_sent++;
    end
  endtask

  initial begin
    logic [CFG_W-1:0] len;
    int               n;
    int               change_at;
    spread_t          spread;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // length from reset, field extremes
    send_word(16'h7fff, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h7fff, 1'b1);
    // lone sample
    send_word(16'h8000, 1'b1);

    // length below range acts as 2
    settle_idle();
    write_length(CFG_W'(0));
    send_word(16'd100, 1'b0);
    send_word(-16'sd100, 1'b0);
    send_word(16'd5, 1'b1);

    // length above range acts as the maximum; early inserts stay silent
    settle_idle();
    write_length(CFG_W'(63));
    send_word(16'h1234, 1'b0);
    send_word(16'h8001, 1'b0);
    send_word(16'h7ffe, 1'b0);
    send_word(16'hfff0, 1'b1);

    // shrink mid-stream so the replace slot wraps
    settle_idle();
    write_length(CFG_W'(4));
    send_word(16'd7, 1'b0);
    send_word(16'd3, 1'b0);
    send_word(-16'sd9, 1'b0);
    settle_idle();
    write_length(CFG_W'(1));
    send_word(16'd11, 1'b0);
    send_word(-16'sd2, 1'b1);

    while (rand_sent < RAND_ITEMS) begin
      quiet = (rand_sent >= QUIET_AFTER);
      settle_idle();
      len = pick_length();
      write_length(len);
      n = (len >= 16) ? $urandom_range(1, 40) : $urandom_range(1, 14);
      change_at = (n > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : -1;
      case ($urandom_range(0, 3))
        0:       spread = SPREAD_NARROW;
        1:       spread = SPREAD_EDGE;
        default: spread = SPREAD_FULL;
      endcase
      play_stream(n, spread, change_at);
    end

    settle_idle();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/smf_pkg.sv
sv/smf_sorter.sv
sv/sliding_window_median_filter.sv
sim/smf_median_checker.sv
sim/sliding_window_median_filter_tb.sv
